// ===== design/trn_pkg.sv =====
// Shared types, codes and constants for the telnet receive negotiator.
// No dependencies.
package trn_pkg;

  localparam int MAX_NAME_BYTES_DEF = 8;

  localparam logic [7:0] T_SE   = 8'd240;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_IAC  = 8'd255;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;
  localparam logic [7:0] OPT_ENV   = 8'd39;

  // register indexes
  localparam logic [2:0] REG_COLS  = 3'd0;
  localparam logic [2:0] REG_ROWS  = 3'd1;
  localparam logic [2:0] REG_TTC   = 3'd2;
  localparam logic [2:0] REG_TTL   = 3'd3;
  localparam logic [2:0] REG_USC   = 3'd4;
  localparam logic [2:0] REG_USL   = 3'd5;
  localparam logic [2:0] REG_IDP   = 3'd6;

  // result run kinds
  localparam logic [2:0] RUN_DATA  = 3'd0;
  localparam logic [2:0] RUN_NEG   = 3'd1;
  localparam logic [2:0] RUN_NAWS  = 3'd2;
  localparam logic [2:0] RUN_TTYPE = 3'd3;
  localparam logic [2:0] RUN_ENV   = 3'd4;

  typedef struct packed {
    logic [15:0] window_columns;
    logic [15:0] window_rows;
    logic [63:0] term_type_chars;
    logic [3:0]  term_type_len;
    logic [63:0] user_chars;
    logic [3:0]  user_len;
    logic [1:0]  identity_present;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;  // data byte or option
    logic [7:0] code;   // reply command
    logic       naws;   // NAWS report follows the reply
  } run_t;

  function automatic logic [7:0] fallback_char(input logic [4:0] k);
    logic [7:0] c;
    case (k)
      5'd0: c = 8'h76;
      5'd1: c = 8'h74;
      5'd2: c = 8'h31;
      5'd3: c = 8'h30;
      5'd4: c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/trn_cfg.sv =====
// APB register file for the negotiator configuration.
// Depends on trn_pkg.
module trn_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  output trn_pkg::cfg_t cfg
);
  import trn_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_columns   <= 16'd80;
      cfg.window_rows      <= 16'd24;
      cfg.term_type_chars  <= '0;
      cfg.term_type_len    <= '0;
      cfg.user_chars       <= '0;
      cfg.user_len         <= '0;
      cfg.identity_present <= '0;
    end else if (wr) begin
      case (idx)
        REG_COLS: cfg.window_columns   <= pwdata[15:0];
        REG_ROWS: cfg.window_rows      <= pwdata[15:0];
        REG_TTC:  cfg.term_type_chars  <= pwdata;
        REG_TTL:  cfg.term_type_len    <= pwdata[3:0];
        REG_USC:  cfg.user_chars       <= pwdata;
        REG_USL:  cfg.user_len         <= pwdata[3:0];
        REG_IDP:  cfg.identity_present <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLS: prdata = {48'd0, cfg.window_columns};
      REG_ROWS: prdata = {48'd0, cfg.window_rows};
      REG_TTC:  prdata = cfg.term_type_chars;
      REG_TTL:  prdata = {60'd0, cfg.term_type_len};
      REG_USC:  prdata = cfg.user_chars;
      REG_USL:  prdata = {60'd0, cfg.user_len};
      REG_IDP:  prdata = {62'd0, cfg.identity_present};
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== design/trn_parser.sv =====
// Telnet command parser: updates parse state per accepted word and loads
// a run descriptor for the serialiser. Depends on trn_pkg.
module trn_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic          func,
  input  logic [7:0]    rx_byte,
  input  trn_pkg::cfg_t cfg,
  input  logic          run_done,
  output logic          run_valid,
  output trn_pkg::run_t run
);
  import trn_pkg::*;

  localparam logic [2:0] PS_NORMAL = 3'd0;
  localparam logic [2:0] PS_IAC    = 3'd1;
  localparam logic [2:0] PS_NEG    = 3'd2;
  localparam logic [2:0] PS_SB     = 3'd3;
  localparam logic [2:0] PS_SBBODY = 3'd4;
  localparam logic [2:0] PS_SBIAC  = 3'd5;

  logic [2:0] parse_state, parse_state_next;
  logic [7:0] pending_code, pending_code_next;
  // only the NAWS entry of the DO store is ever consulted
  logic       naws_agreed, naws_agreed_next;
  logic       accept, produce, ok;
  run_t       run_next;

  assign stall = run_valid && !run_done;
  assign accept = valid && !stall;

  always_comb begin
    parse_state_next  = parse_state;
    pending_code_next = pending_code;
    naws_agreed_next  = naws_agreed;
    produce  = 1'b0;
    run_next = '{kind: RUN_DATA, value: rx_byte, code: T_IAC, naws: 1'b0};
    ok = 1'b0;
    if (pending_code == T_WILL)
      ok = (rx_byte == OPT_ECHO) || (rx_byte == OPT_SGA) || (rx_byte == OPT_NAWS);
    else if (pending_code == T_DO)
      ok = (rx_byte == OPT_SGA) || (rx_byte == OPT_NAWS) ||
           ((rx_byte == OPT_TTYPE) && cfg.identity_present[0]) ||
           ((rx_byte == OPT_ENV) && cfg.identity_present[1]);
    if (func) begin
      if (naws_agreed) begin
        produce = 1'b1;
        run_next.kind = RUN_NAWS;
      end
    end else begin
      case (parse_state)
        PS_NORMAL: begin
          if (rx_byte == T_IAC) parse_state_next = PS_IAC;
          else produce = 1'b1;
        end
        PS_IAC: begin
          if (rx_byte == T_IAC) begin
            produce = 1'b1;
            parse_state_next = PS_NORMAL;
          end else if (rx_byte == T_SB) begin
            parse_state_next = PS_SB;
          end else if (rx_byte >= T_WILL) begin
            pending_code_next = rx_byte;
            parse_state_next = PS_NEG;
          end else begin
            parse_state_next = PS_NORMAL;
          end
        end
        PS_NEG: begin
          parse_state_next = PS_NORMAL;
          run_next.kind = RUN_NEG;
          if (pending_code == T_WILL || pending_code == T_WONT) begin
            produce = 1'b1;
            run_next.code = ok ? T_DO : T_DONT;
          end else if (pending_code == T_DO || pending_code == T_DONT) begin
            produce = 1'b1;
            run_next.code = ok ? T_WILL : T_WONT;
            run_next.naws = ok && (rx_byte == OPT_NAWS);
            if (rx_byte == OPT_NAWS) naws_agreed_next = ok;
          end
        end
        PS_SB: begin
          pending_code_next = rx_byte;
          parse_state_next = PS_SBBODY;
        end
        PS_SBBODY: begin
          if (rx_byte == T_IAC) parse_state_next = PS_SBIAC;
        end
        PS_SBIAC: begin
          if (rx_byte == T_SE) begin
            parse_state_next = PS_NORMAL;
            if (pending_code == OPT_TTYPE) begin
              produce = 1'b1;
              run_next.kind = RUN_TTYPE;
            end else if (pending_code == OPT_ENV) begin
              produce = 1'b1;
              run_next.kind = RUN_ENV;
            end
          end else begin
            parse_state_next = PS_SBBODY;
          end
        end
        default: parse_state_next = PS_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= PS_NORMAL;
      pending_code <= '0;
      naws_agreed  <= 1'b0;
      run_valid    <= 1'b0;
    end else begin
      if (accept) begin
        parse_state  <= parse_state_next;
        pending_code <= pending_code_next;
        naws_agreed  <= naws_agreed_next;
      end
      if (accept && produce) run_valid <= 1'b1;
      else if (run_done) run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) run <= run_next;
  end

endmodule

// ===== design/trn_serial.sv =====
// Result serialiser: walks a run descriptor one output word per cycle
// unless stalled. Depends on trn_pkg.
module trn_serial #(
  parameter int MAX_NAME_BYTES = trn_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          run_valid,
  input  trn_pkg::run_t run,
  input  trn_pkg::cfg_t cfg,
  output logic          run_done,
  output logic          valid,
  input  logic          stall,
  output logic          dest,
  output logic [7:0]    out_byte,
  output logic          last
);
  import trn_pkg::*;

  localparam logic [3:0] MAXN = 4'(MAX_NAME_BYTES);

  logic [4:0]  idx;
  logic [4:0]  base, len, off, nidx;
  logic [3:0]  nlen, tlen, ulen;
  logic [63:0] chars;
  logic [7:0]  name_b, naws_b;
  logic        take;

  assign valid = run_valid;
  assign dest = (run.kind != RUN_DATA);
  assign take = valid && !stall;
  assign run_done = take && last;

  assign tlen = (cfg.term_type_len > MAXN) ? MAXN : cfg.term_type_len;
  assign ulen = (cfg.user_len > MAXN) ? MAXN : cfg.user_len;

  always_comb begin
    nidx = (run.kind == RUN_NEG) ? idx - 5'd3 : idx;
    case (nidx)
      5'd0: naws_b = T_IAC;
      5'd1: naws_b = T_SB;
      5'd2: naws_b = OPT_NAWS;
      5'd3: naws_b = cfg.window_columns[15:8];
      5'd4: naws_b = cfg.window_columns[7:0];
      5'd5: naws_b = cfg.window_rows[15:8];
      5'd6: naws_b = cfg.window_rows[7:0];
      5'd7: naws_b = T_IAC;
      default: naws_b = T_SE;
    endcase
  end

  always_comb begin
    base  = 5'd4;
    nlen  = 4'd5;
    chars = cfg.term_type_chars;
    if (run.kind == RUN_ENV) begin
      base  = 5'd10;
      nlen  = cfg.identity_present[1] ? ulen : 4'd0;
      chars = cfg.user_chars;
    end else if (cfg.identity_present[0]) begin
      nlen = tlen;
    end
    off = idx - base;
    name_b = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (off == 5'(k)) name_b = chars[8*k +: 8];
    end
    if (run.kind == RUN_TTYPE && !cfg.identity_present[0]) name_b = fallback_char(off);
  end

  always_comb begin
    out_byte = run.value;
    len = 5'd1;
    case (run.kind)
      RUN_DATA: begin
        out_byte = run.value;
        len = 5'd1;
      end
      RUN_NEG: begin
        len = run.naws ? 5'd12 : 5'd3;
        if (idx == 5'd0) out_byte = T_IAC;
        else if (idx == 5'd1) out_byte = run.code;
        else if (idx == 5'd2) out_byte = run.value;
        else out_byte = naws_b;
      end
      RUN_NAWS: begin
        len = 5'd9;
        out_byte = naws_b;
      end
      RUN_TTYPE, RUN_ENV: begin
        len = base + 5'(nlen) + 5'd2;
        case (idx)
          5'd0: out_byte = T_IAC;
          5'd1: out_byte = T_SB;
          5'd2: out_byte = (run.kind == RUN_ENV) ? OPT_ENV : OPT_TTYPE;
          5'd3: out_byte = 8'h00;
          default: out_byte = name_b;
        endcase
        if (run.kind == RUN_ENV) begin
          case (idx)
            5'd4: out_byte = 8'h00;
            5'd5: out_byte = 8'h55;
            5'd6: out_byte = 8'h53;
            5'd7: out_byte = 8'h45;
            5'd8: out_byte = 8'h52;
            5'd9: out_byte = 8'h01;
            default: ;
          endcase
        end
        if (idx == base + 5'(nlen)) out_byte = T_IAC;
        else if (idx == base + 5'(nlen) + 5'd1) out_byte = T_SE;
      end
      default: begin
        out_byte = run.value;
        len = 5'd1;
      end
    endcase
  end

  assign last = (idx == len - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? 5'd0 : idx + 5'd1;
    end
  end

endmodule

// ===== design/telnet_receive_negotiator_core.sv =====
// Telnet receive negotiator top level: APB registers, parser, serialiser.
// A word is parsed in the cycle it is accepted; its result run starts the
// next cycle and leaves one word per cycle unless the output stalls (1 to
// 20 words per run). Plain data sustains that rate; input stalls while a
// longer run drains from the serialiser. Synchronous reset clears parse
// state, option flags and registers to their defaults; no clearing pass.
module telnet_receive_negotiator_core #(
  parameter int MAX_NAME_BYTES = trn_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        dest,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import trn_pkg::*;

  cfg_t cfg;
  run_t run;
  logic run_valid, run_done;

  trn_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  trn_parser u_parser (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall), .func(func),
    .rx_byte(rx_byte), .cfg(cfg), .run_done(run_done), .run_valid(run_valid),
    .run(run)
  );

  trn_serial #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_serial (
    .clk(clk), .rst(rst), .run_valid(run_valid), .run(run), .cfg(cfg),
    .run_done(run_done), .valid(out_valid), .stall(out_stall), .dest(dest),
    .out_byte(out_byte), .last(last)
  );

endmodule
